/* src/cat_pkg.sv */
// Shared types and constants for the compacting allocation table.
package cat_pkg;

    localparam int DEFAULT_DEPTH = 64;
    localparam int ADDR_W        = 64;
    localparam int THREAD_W      = 32;
    localparam int SIZE_W        = 32;
    localparam int SEQ_W         = 31;
    localparam int LIVE_CNT_W    = 7;
    localparam int BYTES_W       = 48;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int IN_DATA_W     = 160;
    localparam int OUT_DATA_W    = 216;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO_ADDR = 2'd3
    } t_status;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [SIZE_W-1:0]   size;
        logic [THREAD_W-1:0] thread;
        logic [ADDR_W-1:0]   addr;
    } t_rec;

    typedef struct packed {
        logic add;
        logic clear;
        logic start;
        t_rec rec;
    } t_cmd;

endpackage

/* src/cat_cell.sv */
// One table entry: holds a record, matches the search key and shifts down under the token.
module cat_cell import cat_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_tok,
    input  logic             i_found,
    input  logic             i_next_valid,
    input  t_rec             i_next_rec,
    output logic             o_valid,
    output t_rec             o_rec,
    output logic             o_tok,
    output logic             o_found,
    output logic             o_done,
    output logic             o_hit_done,
    output logic             o_take,
    output t_rec             o_take_rec
);

    logic r_valid;
    logic r_tok;
    logic r_found;
    t_rec r_rec;
    logic match;
    logic shift;
    logic last;
    logic write;

    assign match  = r_valid && (r_rec.addr == i_cmd.rec.addr);
    assign shift  = r_tok && (r_found || match);
    assign last   = !i_next_valid;
    assign write  = i_cmd.add && (i_count == CNT_W'(IDX));

    assign o_valid    = r_valid;
    assign o_rec      = r_rec;
    assign o_tok      = r_tok && !last;
    assign o_found    = r_found || match;
    assign o_done     = r_tok && last;
    assign o_hit_done = r_tok && last && (r_found || match);
    assign o_take     = r_tok && !r_found && match;
    assign o_take_rec = o_take ? r_rec : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_tok   <= i_tok;
            r_found <= i_found;
            if (write) begin
                r_valid <= 1'b1;
            end else if (shift) begin
                r_valid <= i_next_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (write) begin
            r_rec <= i_cmd.rec;
        end else if (shift) begin
            r_rec <= i_next_rec;
        end
    end

endmodule

/* src/compacting_allocation_table_core.sv */
// Top level of the compacting allocation table: control, totals and the row of entry cells.
//
// Records live packed from entry 0 in a row of cells. Add, clear and the unused opcode are
// answered from the idle state without a walk; an add writes the cell at the live count. A
// remove sends a token down the row one cell per cycle, from entry 0 to the last live entry:
// the first matching cell hands its record to the result and every cell behind the match loads
// its neighbor as the token passes. A remove with a zero address or an empty table is answered
// without a walk. A new item is taken once the previous one is finished and the result register
// is free or being read in the same cycle.
module compacting_allocation_table_core import cat_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // address[63:0], thread_id[95:64], alloc_size[127:96], alloc_seq[158:128], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_address[63:0], out_thread[95:64], out_size[127:96], out_seq[158:128],
    // live_count[165:159], live_bytes[213:166], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [BYTES_W-1:0]    r_bytes, n_bytes;
    logic                  r_ovalid, n_ovalid;
    t_status               r_status, n_status;
    t_rec                  r_orec, n_orec;
    logic [LIVE_CNT_W-1:0] r_ocount, n_ocount;
    logic [BYTES_W-1:0]    r_obytes, n_obytes;
    t_rec                  r_in, n_in;
    t_rec                  r_hold, n_hold;

    t_cmd                  cmd;
    t_rec                  in_rec;
    t_rec                  found_rec;
    logic                  accept;
    logic                  respond;
    logic [LIVE_CNT_W+CNT_W-1:0] cnt_ext;

    logic                  cell_valid [TABLE_DEPTH];
    t_rec                  cell_rec   [TABLE_DEPTH];
    logic                  cell_tok   [TABLE_DEPTH];
    logic                  cell_found [TABLE_DEPTH];
    logic                  cell_done  [TABLE_DEPTH];
    logic                  cell_hit   [TABLE_DEPTH];
    logic                  cell_take  [TABLE_DEPTH];
    t_rec                  cell_trec  [TABLE_DEPTH];

    logic                  walk_done;
    logic                  walk_hit;
    logic                  take_any;
    t_rec                  take_bus;

    assign in_rec.addr   = s_axis_tdata[ADDR_W-1:0];
    assign in_rec.thread = s_axis_tdata[ADDR_W+THREAD_W-1:ADDR_W];
    assign in_rec.size   = s_axis_tdata[ADDR_W+THREAD_W+SIZE_W-1:ADDR_W+THREAD_W];
    assign in_rec.seq    = s_axis_tdata[ADDR_W+THREAD_W+SIZE_W+SEQ_W-1:ADDR_W+THREAD_W+SIZE_W];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic tok_in;
            logic found_in;
            logic next_valid;
            t_rec next_rec;
            if (g == 0) begin : g_head
                assign tok_in   = cmd.start;
                assign found_in = 1'b0;
            end else begin : g_body
                assign tok_in   = cell_tok[g-1];
                assign found_in = cell_found[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_rec   = '0;
            end else begin : g_link
                assign next_valid = cell_valid[g+1];
                assign next_rec   = cell_rec[g+1];
            end
            cat_cell #(
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd),
                .i_count      (r_count),
                .i_tok        (tok_in),
                .i_found      (found_in),
                .i_next_valid (next_valid),
                .i_next_rec   (next_rec),
                .o_valid      (cell_valid[g]),
                .o_rec        (cell_rec[g]),
                .o_tok        (cell_tok[g]),
                .o_found      (cell_found[g]),
                .o_done       (cell_done[g]),
                .o_hit_done   (cell_hit[g]),
                .o_take       (cell_take[g]),
                .o_take_rec   (cell_trec[g])
            );
        end
    endgenerate

    always_comb begin
        walk_done = 1'b0;
        walk_hit  = 1'b0;
        take_any  = 1'b0;
        take_bus  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            walk_done = walk_done | cell_done[i];
            walk_hit  = walk_hit | cell_hit[i];
            take_any  = take_any | cell_take[i];
            take_bus  = take_bus | cell_trec[i];
        end
    end

    assign found_rec = take_any ? take_bus : r_hold;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_bytes   = r_bytes;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_status  = r_status;
        n_orec    = r_orec;
        n_in      = r_in;
        n_hold    = take_any ? take_bus : r_hold;
        respond   = 1'b0;
        cmd.add   = 1'b0;
        cmd.clear = 1'b0;
        cmd.start = 1'b0;
        cmd.rec   = r_in;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in     = in_rec;
                    cmd.rec  = in_rec;
                    n_orec   = '0;
                    n_status = ST_OK;
                    respond  = 1'b1;
                    case (s_axis_tuser)
                        OP_ADD: begin
                            if (in_rec.addr == '0) begin
                                n_status = ST_ZERO_ADDR;
                            end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                cmd.add = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                n_bytes = r_bytes + BYTES_W'(in_rec.size);
                            end
                        end
                        OP_REMOVE: begin
                            if (in_rec.addr == '0) begin
                                n_status = ST_ZERO_ADDR;
                            end else if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                cmd.start = 1'b1;
                                respond   = 1'b0;
                                n_state   = S_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            cmd.clear = 1'b1;
                            n_count   = '0;
                            n_bytes   = '0;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    respond = 1'b1;
                    n_state = S_IDLE;
                    if (walk_hit) begin
                        n_status = ST_OK;
                        n_orec   = found_rec;
                        n_count  = r_count - CNT_W'(1);
                        n_bytes  = r_bytes - BYTES_W'(found_rec.size);
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_orec   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (respond) begin
            n_ovalid = 1'b1;
        end
    end

    assign cnt_ext  = {{LIVE_CNT_W{1'b0}}, n_count};
    assign n_ocount = respond ? cnt_ext[LIVE_CNT_W-1:0] : r_ocount;
    assign n_obytes = respond ? n_bytes : r_obytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_bytes  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bytes  <= n_bytes;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_orec   <= n_orec;
        r_ocount <= n_ocount;
        r_obytes <= n_obytes;
        r_in     <= n_in;
        r_hold   <= n_hold;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {2'b00, r_obytes, r_ocount, r_orec.seq, r_orec.size,
                            r_orec.thread, r_orec.addr};

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for compacting_allocation_table_core: directed table, random traffic.
`timescale 1ns / 100ps

module tb_top;
    import cat_pkg::*;

    localparam int                TABLE_DEPTH  = DEFAULT_DEPTH;
    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
    localparam int                WATCHDOG_MAX = 4000;
    localparam int                DRAIN_CYCLES = 200;
    localparam int                PHASE_ITEMS  = 217;
    localparam logic [ADDR_W-1:0] ADDR_ONES    = '1;
    localparam logic [SIZE_W-1:0] SIZE_ONES    = '1;
    localparam logic [SEQ_W-1:0]  SEQ_ONES     = '1;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [ADDR_W-1:0]     addr;
        logic [THREAD_W-1:0]   thread;
        logic [SIZE_W-1:0]     size;
        logic [SEQ_W-1:0]      seq;
        logic [LIVE_CNT_W-1:0] count;
        logic [BYTES_W-1:0]    bytes;
    } table_result_t;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic [THREAD_W-1:0] thread;
        logic [SIZE_W-1:0]   size;
        logic [SEQ_W-1:0]    seq;
        int                  rep;
        bit                  typed;
        table_result_t       res;
    } stim_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // address[63:0], thread_id[95:64], alloc_size[127:96], alloc_seq[158:128], zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // opcode[1:0]
    logic [OP_W-1:0]       s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_address[63:0], out_thread[95:64], out_size[127:96], out_seq[158:128],
    // live_count[165:159], live_bytes[213:166], zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]   m_axis_tuser;

    logic [ADDR_W-1:0]   tbl_addr   [TABLE_DEPTH];
    logic [THREAD_W-1:0] tbl_thread [TABLE_DEPTH];
    logic [SIZE_W-1:0]   tbl_size   [TABLE_DEPTH];
    logic [SEQ_W-1:0]    tbl_seq    [TABLE_DEPTH];
    int                  live_records = 0;
    logic [BYTES_W-1:0]  live_total   = '0;

    table_result_t pending_results [$];
    table_result_t oldest_result;
    stim_row_t     stim_rows [$];
    logic [ADDR_W-1:0] addr_pool [16];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int gap_pct        = 0;
    int stall_pct      = 0;

    compacting_allocation_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic table_apply(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [THREAD_W-1:0] thread,
                               input logic [SIZE_W-1:0] size, input logic [SEQ_W-1:0] seq,
                               output table_result_t res);
        int hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        case (op)
            OP_ADD: begin
                if (addr == '0) begin
                    res.status = ST_ZERO_ADDR;
                end else if (live_records >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    tbl_addr[live_records]   = addr;
                    tbl_thread[live_records] = thread;
                    tbl_size[live_records]   = size;
                    tbl_seq[live_records]    = seq;
                    live_records++;
                    live_total = live_total + BYTES_W'(size);
                end
            end
            OP_REMOVE: begin
                if (addr == '0) begin
                    res.status = ST_ZERO_ADDR;
                end else begin
                    for (int i = live_records - 1; i >= 0; i--) begin
                        if (tbl_addr[i] == addr) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.addr   = tbl_addr[hit];
                        res.thread = tbl_thread[hit];
                        res.size   = tbl_size[hit];
                        res.seq    = tbl_seq[hit];
                        live_total = live_total - BYTES_W'(tbl_size[hit]);
                        for (int i = hit; i < TABLE_DEPTH - 1; i++) begin
                            tbl_addr[i]   = tbl_addr[i + 1];
                            tbl_thread[i] = tbl_thread[i + 1];
                            tbl_size[i]   = tbl_size[i + 1];
                            tbl_seq[i]    = tbl_seq[i + 1];
                        end
                        tbl_addr[TABLE_DEPTH - 1]   = '0;
                        tbl_thread[TABLE_DEPTH - 1] = '0;
                        tbl_size[TABLE_DEPTH - 1]   = '0;
                        tbl_seq[TABLE_DEPTH - 1]    = '0;
                        live_records--;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    tbl_addr[i]   = '0;
                    tbl_thread[i] = '0;
                    tbl_size[i]   = '0;
                    tbl_seq[i]    = '0;
                end
                live_records = 0;
                live_total   = '0;
            end
            default: ;
        endcase
        res.count = LIVE_CNT_W'(live_records);
        res.bytes = live_total;
    endtask

    function automatic table_result_t typed_res(input logic [STATUS_W-1:0] status,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [THREAD_W-1:0] thread,
                                                input logic [SIZE_W-1:0] size,
                                                input logic [SEQ_W-1:0] seq,
                                                input int count,
                                                input logic [BYTES_W-1:0] bytes);
        table_result_t r;
        r.status = status;
        r.addr   = addr;
        r.thread = thread;
        r.size   = size;
        r.seq    = seq;
        r.count  = LIVE_CNT_W'(count);
        r.bytes  = bytes;
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [THREAD_W-1:0] thread, input logic [SIZE_W-1:0] size,
                           input logic [SEQ_W-1:0] seq, input int rep, input bit typed,
                           input table_result_t res);
        stim_row_t row;
        row.op     = op;
        row.addr   = addr;
        row.thread = thread;
        row.size   = size;
        row.seq    = seq;
        row.rep    = rep;
        row.typed  = typed;
        row.res    = res;
        stim_rows.push_back(row);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [THREAD_W-1:0] thread, input logic [SIZE_W-1:0] size,
                             input logic [SEQ_W-1:0] seq, input bit typed,
                             input table_result_t typed_exp);
        table_result_t pred;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, seq, size, thread, addr};
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        table_apply(op, addr, thread, size, seq, pred);
        pending_results.push_back(typed ? typed_exp : pred);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n_items);
        int                  add_pct;
        int                  pick;
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        add_pct = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 80 == 0) begin
                add_pct = ($urandom_range(1) == 1) ? 85 : 30;
            end
            pick = $urandom_range(99);
            if (pick < 1) begin
                op = OP_CLEAR;
            end else if (pick < 3) begin
                op = OP_UNUSED;
            end else if ($urandom_range(99) < add_pct) begin
                op = OP_ADD;
            end else begin
                op = OP_REMOVE;
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                addr = '0;
            end else if (op == OP_REMOVE && live_records > 0 && pick < 75) begin
                addr = tbl_addr[$urandom_range(live_records - 1)];
            end else if (pick < 50) begin
                addr = addr_pool[$urandom_range(15)];
            end else begin
                addr = {$urandom, $urandom};
            end
            send_item(op, addr, $urandom, $urandom, SEQ_W'($urandom), 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tuser, '0);
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status", m_axis_tuser, oldest_result.status);
                check_field("out_address", m_axis_tdata[63:0], oldest_result.addr);
                check_field("out_thread", m_axis_tdata[95:64], oldest_result.thread);
                check_field("out_size", m_axis_tdata[127:96], oldest_result.size);
                check_field("out_seq", m_axis_tdata[158:128], oldest_result.seq);
                check_field("live_count", m_axis_tdata[165:159], oldest_result.count);
                check_field("live_bytes", m_axis_tdata[213:166], oldest_result.bytes);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_MAX) begin
                $display("** compacting_allocation_table_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t row;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_addr[i]   = '0;
            tbl_thread[i] = '0;
            tbl_size[i]   = '0;
            tbl_seq[i]    = '0;
        end
        for (int i = 0; i < 16; i++) begin
            addr_pool[i] = {$urandom, $urandom} | 64'h1;
        end

        add_row(OP_REMOVE, 64'd5, 0, 0, 0, 1, 1'b1, typed_res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        add_row(OP_ADD, '0, '1, SIZE_ONES, SEQ_ONES, 1, 1'b1,
                typed_res(ST_ZERO_ADDR, 0, 0, 0, 0, 0, 0));
        add_row(OP_REMOVE, '0, 0, 0, 0, 1, 1'b1, typed_res(ST_ZERO_ADDR, 0, 0, 0, 0, 0, 0));
        add_row(OP_UNUSED, ADDR_ONES, '1, SIZE_ONES, SEQ_ONES, 1, 1'b1,
                typed_res(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(OP_ADD, ADDR_ONES, '1, SIZE_ONES, SEQ_ONES, 1, 1'b1,
                typed_res(ST_OK, 0, 0, 0, 0, 1, 48'hFFFF_FFFF));
        add_row(OP_ADD, 64'd1, 0, 0, 0, 1, 1'b1, typed_res(ST_OK, 0, 0, 0, 0, 2, 48'hFFFF_FFFF));
        add_row(OP_ADD, 64'd1, 32'd7, 32'd16, 31'd3, 1, 1'b0, '0);
        add_row(OP_REMOVE, 64'd1, 0, 0, 0, 1, 1'b0, '0);
        add_row(OP_REMOVE, ADDR_ONES, 0, 0, 0, 1, 1'b1,
                typed_res(ST_OK, ADDR_ONES, '1, SIZE_ONES, SEQ_ONES, 1, 48'd16));
        add_row(OP_REMOVE, 64'd1, 0, 0, 0, 1, 1'b0, '0);
        add_row(OP_REMOVE, 64'd1, 0, 0, 0, 1, 1'b1, typed_res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        add_row(OP_ADD, 64'h100, 32'h5A5A_A5A5, SIZE_ONES, 31'h5555_5555, TABLE_DEPTH, 1'b0, '0);
        add_row(OP_ADD, 64'h200, 0, 0, 0, 1, 1'b1,
                typed_res(ST_FULL, 0, 0, 0, 0, TABLE_DEPTH, 48'h3F_FFFF_FFC0));
        add_row(OP_ADD, '0, 0, 0, 0, 1, 1'b1,
                typed_res(ST_ZERO_ADDR, 0, 0, 0, 0, TABLE_DEPTH, 48'h3F_FFFF_FFC0));
        add_row(OP_REMOVE, 64'h100 + TABLE_DEPTH - 1, 0, 0, 0, 1, 1'b0, '0);
        add_row(OP_REMOVE, 64'h100, 0, 0, 0, 1, 1'b0, '0);
        add_row(OP_REMOVE, 64'h120, 0, 0, 0, 1, 1'b0, '0);
        add_row(OP_UNUSED, 64'h121, 0, 0, 0, 1, 1'b0, '0);
        add_row(OP_CLEAR, 64'h101, 0, 0, 0, 1, 1'b1, typed_res(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(OP_REMOVE, 64'h101, 0, 0, 0, 1, 1'b1, typed_res(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[n]) begin
            row = stim_rows[n];
            for (int r = 0; r < row.rep; r++) begin
                send_item(row.op, row.addr + ADDR_W'(r), row.thread, row.size, row.seq,
                          row.typed, row.res);
            end
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("** compacting_allocation_table_core: PASSED **");
        end else begin
            $display("** compacting_allocation_table_core: FAILED **");
        end
        $finish;
    end

endmodule

/* compacting_allocation_table_core.f */
src/cat_pkg.sv
src/cat_cell.sv
src/compacting_allocation_table_core.sv
sim/tb_top.sv
